// ----- rtl/rdc_pkg.sv -----
// Package: shared constants, types and the digit-to-ASCII mapping of the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

  // Fixed field widths.
  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;

  // Default significant width of the value.
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // Digit stack depth and the width of a count that can hold it.
  localparam int STORE_DEPTH = 32;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

  // Accepted range of the base.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // Character constants.
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_MASK  = DIGIT_W'(15);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  CHAR_NINE   = CHAR_W'(8'h39);
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_F = CHAR_W'(8'h46);
  localparam logic [CHAR_W-1:0]  CHAR_ERROR  = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT,
    S_ERR
  } rdc_state_t;

  // Commands from the sequencer to the divider.
  typedef struct packed {
    logic start;   // load a new value and base, begin a division
    logic again;   // divide the current quotient once more
  } div_ctrl_t;

  // Status from the divider.
  typedef struct packed {
    logic done;       // one cycle: quotient and remainder are final
    logic quot_zero;  // quotient is zero
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dm;
    dm = d & DIGIT_MASK;
    if (dm >= DEC_DIGITS) begin
      return CHAR_UPPER_A + CHAR_W'(dm - DEC_DIGITS);
    end
    return CHAR_ZERO + CHAR_W'(dm);
  endfunction

endpackage

// ----- rtl/rdc_in_if.sv -----
// Interface: input channel carrying a value and a base.
`timescale 1ns / 1ps

interface rdc_in_if import rdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface

// ----- rtl/rdc_out_if.sv -----
// Interface: output channel carrying one ASCII digit with its flags.
`timescale 1ns / 1ps

interface rdc_out_if import rdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  logic              bad_radix;

  modport source (output valid, digit_char, last, bad_radix, input ready);
  modport sink   (input valid, digit_char, last, bad_radix, output ready);
endinterface

// ----- rtl/rdc_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, base up to 16.
`timescale 1ns / 1ps

module rdc_div import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
  localparam int EW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W
) (
  input  logic               clk,
  input  logic               rst,
  input  div_ctrl_t          ctrl,
  input  logic [EW-1:0]      load_value,
  input  logic [RADIX_W-1:0] load_radix,
  output div_stat_t          stat,
  output logic [DIGIT_W-1:0] remainder
);

  localparam int CW = $clog2(EW);

  logic [EW-1:0]      quot;
  logic [DIGIT_W-1:0] rem;
  logic [RADIX_W-1:0] radix;
  logic [CW-1:0]      bit_cnt;
  logic               running;
  logic               done;

  logic [RADIX_W-1:0] trial;
  logic               fits;

  // Bring down the next dividend bit and try to subtract the base.
  assign trial = {rem, quot[EW-1]};
  assign fits  = (trial >= radix);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start || ctrl.again) begin
        running <= 1'b1;
      end else if (running && (bit_cnt == CW'(EW - 1))) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quot    <= load_value;
      radix   <= load_radix;
      rem     <= '0;
      bit_cnt <= '0;
    end else if (ctrl.again) begin
      rem     <= '0;
      bit_cnt <= '0;
    end else if (running) begin
      quot    <= {quot[EW-2:0], fits};
      rem     <= fits ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
      bit_cnt <= bit_cnt + CW'(1);
    end
  end

  assign stat.done      = done;
  assign stat.quot_zero = (quot == '0);
  assign remainder      = rem;

endmodule

// ----- rtl/radix_digit_converter_top.sv -----
// Top level: converts an unsigned value to ASCII digits in a base from 2 to 16.
`timescale 1ns / 1ps

//  Channel   Direction  Payload                          Transfer
//  in_item   sink       value[31:0], radix[4:0]          valid && ready
//  out_item  source     digit_char[6:0], last, bad_radix valid && ready
//
// Each digit comes from one full bit-serial division over the significant value width
// (VALUE_WIDTH, capped at 32), with a hand-over step between divisions; the digits are
// then played out one per cycle if the sink keeps ready. A base outside 2..16 skips the
// divider and gives an error result. Reset clears the sequencer, the digit count and
// the output valid flag; no clearing pass is needed. A stalled sink holds the current
// digit, and a new value is taken only once the last digit of the previous one is in
// the output register.

module radix_digit_converter_top import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  rdc_in_if.sink      in_item,
  rdc_out_if.source   out_item
);

  // Significant width of the value: the field itself is only 32 bits wide.
  localparam int EW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;

  rdc_state_t state;
  rdc_state_t state_next;

  // Digit stack: remainders are pushed least significant first and popped from
  // the same end, so the most significant digit leaves first.
  logic [DIGIT_W-1:0] digit_stack [STORE_DEPTH];
  logic [COUNT_W-1:0] digit_count;

  logic               push;
  logic               pop;
  logic               in_fire;
  logic               radix_ok;
  logic               out_free;
  logic               out_load;
  logic               out_load_err;

  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  logic               out_bad;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [DIGIT_W-1:0] div_rem;

  assign in_item.ready = (state == S_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;
  assign radix_ok      = (in_item.radix >= RADIX_MIN) && (in_item.radix <= RADIX_MAX);
  assign out_free      = !out_valid || out_item.ready;

  rdc_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (div_ctrl),
    .load_value (in_item.value[EW-1:0]),
    .load_radix (in_item.radix),
    .stat       (div_stat),
    .remainder  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: starts divisions, collects remainders and plays them out, or flags a bad base.
  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    div_ctrl.again = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    out_load       = 1'b0;
    out_load_err   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (radix_ok) begin
            div_ctrl.start = 1'b1;
            state_next     = S_DIV;
          end else begin
            state_next = S_ERR;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          push = 1'b1;
          // A zero quotient means every digit is in; a zero value still gives one.
          if (div_stat.quot_zero) begin
            state_next = S_EMIT;
          end else begin
            div_ctrl.again = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          pop      = 1'b1;
          if (digit_count == COUNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      digit_stack[0] <= div_rem;
      for (int i = 1; i < STORE_DEPTH; i++) begin
        digit_stack[i] <= digit_stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
        digit_stack[i] <= digit_stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (div_ctrl.start) begin
      digit_count <= '0;
    end else if (push) begin
      digit_count <= digit_count + COUNT_W'(1);
    end else if (pop) begin
      digit_count <= digit_count - COUNT_W'(1);
    end
  end

  // Output register: holds the current digit while the sink stalls; the sequencer loads it only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load || out_load_err) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= digit_to_ascii(digit_stack[0]);
      out_last <= (digit_count == COUNT_W'(1));
      out_bad  <= 1'b0;
    end else if (out_load_err) begin
      out_char <= CHAR_ERROR;
      out_last <= 1'b1;
      out_bad  <= 1'b1;
    end
  end

  assign out_item.valid      = out_valid;
  assign out_item.digit_char = out_char;
  assign out_item.last       = out_last;
  assign out_item.bad_radix  = out_bad;

endmodule

// ----- rtl/rdc_chk.sv -----
// Checker: port-level assertions for the radix digit converter, bound to the top level.
`timescale 1ns / 1ps

module rdc_chk import rdc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] digit_char,
  input logic              last,
  input logic              bad_radix
);

  // An error result is a single, final character of value zero.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_radix) |-> (digit_char == CHAR_ERROR && last))
    else $error("error result with wrong character or without last mark");

  // A normal result is always a hexadecimal ASCII digit.
  a_digit_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !bad_radix) |->
      ((digit_char >= CHAR_ZERO && digit_char <= CHAR_NINE) ||
       (digit_char >= CHAR_UPPER_A && digit_char <= CHAR_UPPER_F)))
    else $error("digit character out of range");

  // One value at a time: the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped without a transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      ($stable(digit_char) && $stable(last) && $stable(bad_radix)))
    else $error("output payload changed while stalled");

endmodule

bind radix_digit_converter_top rdc_chk u_rdc_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_item.valid),
  .in_ready   (in_item.ready),
  .out_valid  (out_item.valid),
  .out_ready  (out_item.ready),
  .digit_char (out_item.digit_char),
  .last       (out_item.last),
  .bad_radix  (out_item.bad_radix)
);

// ----- test/rdc_checker.sv -----
// Checker for the radix digit converter: watches both channels and scores every digit.
`timescale 1ns / 1ps

module rdc_checker import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  rdc_in_if    in_ch,
  rdc_out_if   out_ch,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_radix;
  } digit_exp_t;

  digit_exp_t digit_q[$];

  assign outstanding = digit_q.size();

  initial fail_count = 0;

  // Queues the digits of one conversion, most significant first, or one error entry for a bad base.
  function automatic void predict_digits(input logic [IN_VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    digit_exp_t         e;
    logic [DIGIT_W-1:0] rems[$];
    logic [31:0]        quot;
    logic [DIGIT_W-1:0] d;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      e = '{CHAR_ERROR, 1'b1, 1'b1};
      digit_q.push_back(e);
      return;
    end
    quot = value;
    if (VALUE_WIDTH < 32) begin
      quot = quot & ((32'd1 << VALUE_WIDTH) - 32'd1);
    end
    if (quot == 0) begin
      e = '{CHAR_ZERO, 1'b1, 1'b0};
      digit_q.push_back(e);
      return;
    end
    while (quot != 0) begin
      rems.push_front(DIGIT_W'(quot % 32'(radix)));
      quot = quot / 32'(radix);
    end
    foreach (rems[k]) begin
      d = rems[k];
      e.digit_char = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_UPPER_A + CHAR_W'(d - 10);
      e.last       = (k == rems.size() - 1);
      e.bad_radix  = 1'b0;
      digit_q.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    digit_exp_t exp_d;
    logic       bad;
    if (!rst) begin
      // Results first: a digit on the output never belongs to a value taken in the same cycle.
      if (out_ch.valid && out_ch.ready) begin
        if (digit_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected digit char=%h last=%b bad_radix=%b", $time,
                     out_ch.digit_char, out_ch.last, out_ch.bad_radix);
          end
        end else begin
          exp_d = digit_q.pop_front();
          bad = (out_ch.digit_char !== exp_d.digit_char) ||
                (out_ch.last !== exp_d.last) ||
                (out_ch.bad_radix !== exp_d.bad_radix);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: digit mismatch: expected char=%h last=%b bad_radix=%b, got char=%h last=%b bad_radix=%b",
                       $time, exp_d.digit_char, exp_d.last, exp_d.bad_radix,
                       out_ch.digit_char, out_ch.last, out_ch.bad_radix);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value, in_ch.radix);
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench top: drives values and bases into the radix digit converter and gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import rdc_pkg::*;

  // The slowest conversion is 32 binary digits, each from a full division, and the output
  // side may stall on every digit, so this limit leaves a wide margin over a correct run.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 350;
  localparam int LONG_HOLD    = 1500;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   sent_count;
  int   cycle_count;
  logic calm;
  logic long_hold_done;

  rdc_in_if  in_ch ();
  rdc_out_if out_ch ();

  radix_digit_converter_top DUT (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  rdc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Two windows in which neither side idles, so that back-to-back transfers are exercised.
  assign calm = (sent_count >= 60 && sent_count < 90) || (sent_count >= 260 && sent_count < 290);

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Mostly valid bases, with a good share of out-of-range ones across the whole 5-bit field.
  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(99) < 80) begin
      return RADIX_W'($urandom_range(2, 16));
    end
    return RADIX_W'($urandom_range(0, 31));
  endfunction

  // Values chosen to hit digit-count boundaries as well as plain random ones.
  function automatic logic [IN_VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] radix);
    int          r;
    int          k;
    logic [63:0] p;
    logic [63:0] b;
    r = $urandom_range(9);
    case (r)
      0, 1, 2, 3: begin
        return $urandom;
      end
      4, 5: begin
        return $urandom_range(0, 300);
      end
      6: begin
        return $urandom_range(0, 1);
      end
      7: begin
        // A power of the base, or one below it, so that the digit count just changes.
        b = (radix >= RADIX_MIN && radix <= RADIX_MAX) ? 64'(radix) : 64'd10;
        k = $urandom_range(1, 32);
        p = 64'd1;
        repeat (k) begin
          if (p * b <= 64'h1_0000_0000) begin
            p = p * b;
          end
        end
        if (p > 64'hFFFF_FFFF || $urandom_range(1) == 1) begin
          p = p - 64'd1;
        end
        return p[IN_VALUE_W-1:0];
      end
      8: begin
        return 32'd1 << $urandom_range(31);
      end
      default: begin
        return 32'hFFFF_FFFF >> $urandom_range(31);
      end
    endcase
  endfunction

  // Offers one item and holds it until the block takes it. The valid line is only
  // lowered when a gap follows, so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic [IN_VALUE_W-1:0] value,
                           input logic [RADIX_W-1:0] radix, input int gap);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.radix <= radix;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sent_count++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The sender pauses here until every digit it has caused has been transferred. It first
  // waits for the checker to queue the digits of the latest transfer.
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Output side: random stalls of varied length, and once a long hold-off while the
  // sender keeps offering items, so that the block fills up and stops taking input.
  initial begin
    int r;
    int stall;
    long_hold_done = 1'b0;
    forever begin
      if (!long_hold_done && sent_count >= 120) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(99);
        if (calm || r < 55) begin
          stall = 0;
        end else if (r < 90) begin
          stall = $urandom_range(1, 3);
        end else if (r < 97) begin
          stall = $urandom_range(4, 12);
        end else begin
          stall = $urandom_range(20, 60);
        end
        if (stall == 0) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [RADIX_W-1:0] radix;
    sent_count  = 0;
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.radix <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: zero values, the widest and narrowest results, every letter
    // boundary, and bases just outside the legal range at both ends.
    send_item(32'd0,          5'd10, pick_gap());
    send_item(32'd0,          5'd2,  pick_gap());
    send_item(32'hFFFF_FFFF,  5'd2,  pick_gap());
    send_item(32'hFFFF_FFFF,  5'd16, pick_gap());
    send_item(32'hFFFF_FFFF,  5'd10, pick_gap());
    send_item(32'h8000_0000,  5'd2,  pick_gap());
    send_item(32'd1,          5'd2,  pick_gap());
    send_item(32'd1,          5'd16, pick_gap());
    send_item(32'd15,         5'd16, pick_gap());
    send_item(32'd10,         5'd16, pick_gap());
    send_item(32'hDEAD_BEEF,  5'd16, pick_gap());
    send_item(32'h0123_4567,  5'd16, pick_gap());
    send_item(32'h89AB_CDEF,  5'd16, pick_gap());
    send_item(32'd12345,      5'd10, pick_gap());
    send_item(32'd35,         5'd3,  pick_gap());
    send_item(32'd7,          5'd7,  pick_gap());
    send_item(32'd255,        5'd15, pick_gap());
    send_item(32'd0,          5'd0,  pick_gap());
    send_item(32'd1234,       5'd1,  pick_gap());
    send_item(32'd99,         5'd17, pick_gap());
    send_item(32'hFFFF_FFFF,  5'd31, pick_gap());
    send_item(32'hAAAA_5555,  5'd13, 0);
    in_ch.valid <= 1'b0;
    drain();

    // Random part, with one pause halfway through until the block has drained.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 180) begin
        in_ch.valid <= 1'b0;
        drain();
      end
      radix = pick_radix();
      send_item(pick_value(radix), radix, pick_gap());
    end
    in_ch.valid <= 1'b0;

    // Wait for the last digits, then a little longer to catch any stray transfer.
    drain();
    repeat (50) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rdc_pkg.sv
rtl/rdc_in_if.sv
rtl/rdc_out_if.sv
rtl/rdc_div.sv
rtl/radix_digit_converter_top.sv
rtl/rdc_chk.sv
test/rdc_checker.sv
test/testbench.sv
